// ===== sv/unique_pair_map_table_unit_assert.svh =====
// Assertion helpers for the pair map table unit.
// Every check is sampled on clk and disabled while rst_n is low.
`ifndef UNIQUE_PAIR_MAP_TABLE_UNIT_ASSERT_SVH
`define UNIQUE_PAIR_MAP_TABLE_UNIT_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define UPMT_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define UPMT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== sv/upmt_pkg.sv =====
`timescale 1ns / 1ps

package upmt_pkg;

  // field widths
  localparam int KEY_W   = 8;
  localparam int SLOT_W  = 9;
  localparam int IDX_W   = 8;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = 8;

  // defaults for the top level parameters
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_SLOT_LIMIT  = 128;

  // request codes carried on in_tuser
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_INDEX  = 2'd3
  } kind_t;

  // one stored pair
  typedef struct packed {
    logic [ENTRY_W-1:0] slot;
    logic [KEY_W-1:0]   key;
  } pair_t;

endpackage

// ===== sv/unique_pair_map_table_unit.sv =====
// Pair map table: one word in, one result word out per request.
// out_tvalid rises after accept via S_PUT for clear, refused add and out-of-range read,
// via S_IDX, S_IDXD and S_PUT for read by index. Add and lookup scan one entry per cycle through the one
// table read port, ending early on a hit; S_PUT waits while the output is stalled.
// in_tready is low until the result is loaded, so only one request is in work at a time.
// Synchronous active-low reset empties the table and clears reserved key to 0.
`timescale 1ns / 1ps

module unique_pair_map_table_unit #(
  parameter int MAX_ENTRIES = upmt_pkg::DEF_MAX_ENTRIES,
  parameter int SLOT_LIMIT  = upmt_pkg::DEF_SLOT_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: reserved key
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] key_id, [16:8] slot_number, [24:17] entry_index
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_key, [15:8] out_slot, [20:16] entry_count
  output logic [0:0]  out_tuser   // [0] ok
);
  import upmt_pkg::*;

  `include "unique_pair_map_table_unit_assert.svh"

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0]     MAX_CNT  = CW'(MAX_ENTRIES);
  localparam logic [SLOT_W-1:0] SLOT_LIM = SLOT_W'(SLOT_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_IDX,
    S_IDXD,
    S_PUT
  } state_t;

  state_t state_r, state_nxt;

  // captured request
  kind_t             kind_r, kind_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // scan sequencer
  logic [CW-1:0]     addr_r, addr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [KEY_W-1:0]  rsv_key_r, rsv_key_nxt;

  // pending result
  logic              res_ok_r, res_ok_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [ENTRY_W-1:0] res_slot_r, res_slot_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [ENTRY_W-1:0] out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // table ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  pair_t             wr_pair;
  logic [AW-1:0]     rd_addr;
  pair_t             rd_pair;

  // input fields
  kind_t             in_kind;
  logic [KEY_W-1:0]  in_key;
  logic [SLOT_W-1:0] in_slot;
  logic [IDX_W-1:0]  in_idx;
  logic              in_acc;
  logic              add_pass;
  logic              issue;
  logic              hit;
  logic [31:0]       fill_wide;

  assign in_kind = kind_t'(in_tuser);
  assign in_key  = in_tdata[7:0];
  assign in_slot = in_tdata[16:8];
  assign in_idx  = in_tdata[24:17];
  assign in_acc  = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_slot_r, out_key_r};
  assign out_tuser  = out_ok_r;

  assign fill_wide = 32'(fill_r);

  // add checks that need no scan
  assign add_pass = (in_key != rsv_key_r) && !in_slot[SLOT_W-1] &&
                    (in_slot < SLOT_LIM) && (fill_r < MAX_CNT);

  // scan: one read issued per cycle, compared in the cycle after
  assign issue = (state_r == S_SCAN) && (addr_r < fill_r);
  assign hit   = cmp_vld_r && ((rd_pair.key == key_r) ||
                 ((kind_r == KIND_ADD) && (rd_pair.slot == slot_r[ENTRY_W-1:0])));

  assign rd_addr = (state_r == S_IDX) ? idx_r[AW-1:0] : addr_r[AW-1:0];
  assign wr_addr = fill_r[AW-1:0];
  assign wr_pair = '{slot: slot_r[ENTRY_W-1:0], key: key_r};

  upmt_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_pair (wr_pair),
    .rd_addr (rd_addr),
    .rd_pair (rd_pair)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    cmp_vld_nxt   = 1'b0;
    fill_nxt      = fill_r;
    rsv_key_nxt   = cfg_wr_en ? cfg_wr_data : rsv_key_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_slot_nxt  = out_slot_r;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_kind;
          key_nxt      = in_key;
          slot_nxt     = in_slot;
          idx_nxt      = in_idx;
          addr_nxt     = '0;
          res_ok_nxt   = 1'b0;
          res_key_nxt  = '0;
          res_slot_nxt = '0;
          unique case (in_kind)
            KIND_CLEAR: begin
              fill_nxt   = '0;
              res_ok_nxt = 1'b1;
              state_nxt  = S_PUT;
            end
            KIND_ADD: begin
              state_nxt = add_pass ? S_SCAN : S_PUT;
            end
            KIND_LOOKUP: begin
              state_nxt = S_SCAN;
            end
            KIND_INDEX: begin
              state_nxt = ({1'b0, in_idx} < 9'(fill_r)) ? S_IDX : S_PUT;
            end
            default: begin
              state_nxt = S_PUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        cmp_vld_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (hit) begin
          // lookup hit returns the slot; any match refuses an add
          res_ok_nxt   = (kind_r == KIND_LOOKUP);
          res_slot_nxt = (kind_r == KIND_LOOKUP) ? rd_pair.slot : '0;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = S_PUT;
        end else if (!issue && !cmp_vld_r) begin
          // whole table seen without a match
          if (kind_r == KIND_ADD) begin
            wr_en      = 1'b1;
            fill_nxt   = fill_r + 1'b1;
            res_ok_nxt = 1'b1;
          end
          state_nxt = S_PUT;
        end
      end

      S_IDX: begin
        state_nxt = S_IDXD;
      end

      S_IDXD: begin
        res_ok_nxt   = 1'b1;
        res_key_nxt  = rd_pair.key;
        res_slot_nxt = rd_pair.slot;
        state_nxt    = S_PUT;
      end

      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_key_nxt   = res_key_r;
          out_slot_nxt  = res_slot_r;
          out_cnt_nxt   = fill_wide[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      cmp_vld_r   <= 1'b0;
      fill_r      <= '0;
      rsv_key_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      fill_r      <= fill_nxt;
      rsv_key_r   <= rsv_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_key_r  <= res_key_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_slot_r <= out_slot_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // checks
  `UPMT_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= MAX_CNT, "fill count beyond table depth")
  `UPMT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "accepted while a request is in work")
  `UPMT_ASSERT_NOW(a_write_on_add, wr_en, (kind_r == KIND_ADD) && (fill_r < MAX_CNT), "table written outside a legal add")
  `UPMT_ASSERT_NEXT(a_write_bumps_fill, wr_en, fill_r == $past(fill_r) + 1'b1, "add did not bump fill count")

endmodule

// ===== sv/upmt_table.sv =====
`timescale 1ns / 1ps

// Pair storage: one write port, one read port with registered data.
module upmt_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  upmt_pkg::pair_t       wr_pair,
  input  logic [AW-1:0]         rd_addr,
  output upmt_pkg::pair_t       rd_pair
);
  import upmt_pkg::*;

  pair_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pair;
    end
  end

  // read port, data registered in the cycle after the address
  always_ff @(posedge clk) begin
    rd_pair <= mem[rd_addr];
  end

endmodule
